// ===== design/linear_contrast_stretch_assert.svh =====
// Assertion macros for the linear contrast stretch block.
`ifndef LINEAR_CONTRAST_STRETCH_ASSERT_SVH
`define LINEAR_CONTRAST_STRETCH_ASSERT_SVH
`ifndef SYNTH
`define LCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LCS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define LCS_ASSERT(lbl, prop, msg)
`define LCS_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

// ===== design/lcs_pkg.sv =====
// Shared types and constants of the linear contrast stretch block.
`timescale 1ns / 1ps
`default_nettype none
package lcs_pkg;

  localparam int PIXEL_BITS = 8;
  localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = '1;
  localparam int S_TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int S_TUSER_W = 2;
  localparam int M_TUSER_W = 1;
  localparam int USER_OP = 0;
  localparam int USER_START = 1;
  localparam int STEP_W = $clog2(PIXEL_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PIXEL_BITS - 1);

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_STRETCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_FINISH
  } lcs_state_t;

  typedef struct packed {
    logic measure;
    logic capture;
    logic setup;
    logic step;
    logic load_out;
  } lcs_cmd_t;

  typedef struct packed {
    logic bypass;
    logic last_step;
  } lcs_status_t;

endpackage
`default_nettype wire

// ===== design/lcs_ctrl.sv =====
// Controller state machine: input acceptance, divide sequencing, output slot.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_contrast_stretch_assert.svh"
module lcs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_op,
  input  wire logic                 m_tready,
  input  wire lcs_pkg::lcs_status_t status,
  output lcs_pkg::lcs_cmd_t         cmd,
  output logic                      s_tready,
  output logic                      m_tvalid
);

  lcs_pkg::lcs_state_t state, state_next;
  logic out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcs_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      lcs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_op == lcs_pkg::OP_STRETCH) begin
            cmd.capture = 1'b1;
            state_next = lcs_pkg::ST_SETUP;
          end else begin
            cmd.measure = 1'b1;
          end
        end
      end
      lcs_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_next = status.bypass ? lcs_pkg::ST_FINISH : lcs_pkg::ST_DIVIDE;
      end
      lcs_pkg::ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (status.last_step) begin
          state_next = lcs_pkg::ST_FINISH;
        end
      end
      lcs_pkg::ST_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next = lcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lcs_pkg::ST_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

  `LCS_ASSERT(load_into_free_slot, cmd.load_out |-> (!out_valid || m_tready), "output overwritten")
  `LCS_ASSERT_NEXT(last_step_finishes, state == lcs_pkg::ST_DIVIDE && status.last_step, state == lcs_pkg::ST_FINISH, "divide did not end")
  `LCS_ASSERT(valid_rises_on_load, $rose(out_valid) |-> $past(cmd.load_out), "result without load")

endmodule
`default_nettype wire

// ===== design/lcs_datapath.sv =====
// Datapath: frame levels, saturation checks, restoring divider, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_contrast_stretch_assert.svh"
module lcs_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lcs_pkg::lcs_cmd_t                 cmd,
  input  wire logic [lcs_pkg::S_TDATA_W-1:0]     s_tdata,
  input  wire logic [lcs_pkg::S_TUSER_W-1:0]     s_tuser,
  output lcs_pkg::lcs_status_t                   status,
  output logic [lcs_pkg::M_TDATA_W-1:0]          m_tdata,
  output logic [lcs_pkg::M_TUSER_W-1:0]          m_tuser
);

  localparam int B = lcs_pkg::PIXEL_BITS;

  logic [B-1:0] low_level, high_level;
  logic [B-1:0] pixel, span, rem, dividend_lo, quotient, out_pixel;
  logic flat, out_flat;
  logic [lcs_pkg::STEP_W-1:0] step_count;

  logic [B-1:0] pixel_in;
  logic frame_start;
  logic is_flat, below, above;
  logic [B-1:0] diff;
  logic [2*B-1:0] num;
  logic [B:0] rem_shift, rem_sub;
  logic fits;

  assign pixel_in = s_tdata[B-1:0];
  assign frame_start = s_tuser[lcs_pkg::USER_START];

  assign is_flat = (high_level == low_level);
  assign below = (pixel <= low_level);
  assign above = (pixel >= high_level);
  assign status.bypass = is_flat || below || above;
  assign status.last_step = (step_count == lcs_pkg::LAST_STEP);

  // (p - low) * (2^B - 1) as a shift and a subtract
  assign diff = pixel - low_level;
  assign num = {diff, {B{1'b0}}} - {{B{1'b0}}, diff};

  assign rem_shift = {rem, dividend_lo[B-1]};
  assign fits = (rem_shift >= {1'b0, span});
  assign rem_sub = rem_shift - {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      low_level <= '0;
      high_level <= '0;
    end else if (cmd.measure) begin
      if (frame_start) begin
        low_level <= pixel_in;
        high_level <= pixel_in;
      end else begin
        if (pixel_in < low_level) low_level <= pixel_in;
        if (pixel_in > high_level) high_level <= pixel_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pixel <= pixel_in;
    end
    if (cmd.setup) begin
      flat <= is_flat;
      span <= high_level - low_level;
      rem <= num[2*B-1:B];
      dividend_lo <= num[B-1:0];
      step_count <= '0;
      if (is_flat || below) begin
        quotient <= '0;
      end else begin
        quotient <= lcs_pkg::PIXEL_MAX;
      end
    end
    if (cmd.step) begin
      rem <= fits ? rem_sub[B-1:0] : rem_shift[B-1:0];
      dividend_lo <= {dividend_lo[B-2:0], 1'b0};
      quotient <= {quotient[B-2:0], fits};
      step_count <= step_count + 1'b1;
    end
    if (cmd.load_out) begin
      out_pixel <= quotient;
      out_flat <= flat;
    end
  end

  assign m_tdata = lcs_pkg::M_TDATA_W'(out_pixel);
  assign m_tuser = out_flat;

  `LCS_ASSERT(levels_ordered, low_level <= high_level, "low level above high level")
  `LCS_ASSERT(remainder_below_span, cmd.step |-> rem < span, "divider remainder out of range")
  `LCS_ASSERT_NEXT(flat_gives_zero, cmd.load_out && flat, out_pixel == '0, "flat frame with nonzero pixel")

endmodule
`default_nettype wire

// ===== design/linear_contrast_stretch.sv =====
// Top level of the min/max linear contrast stretch block.
// A measure transaction (tuser operation bit 0) updates the frame's low and high
// levels and gives no result; its frame_start bit reloads both levels with that
// pixel. A stretch transaction (operation bit 1) gives one result, saturated to
// 0 or 255 outside the range, floor((p - low) * 255 / (high - low)) inside it,
// and 0 with flat_frame set when high equals low. A divided stretch pixel goes
// through capture, a setup state, eight restoring divider steps at one quotient
// bit each and an output load that waits for a free output register; only then
// is the next transaction accepted. A saturated or flat pixel skips the divider,
// which is the rate limit; a result waits in the output register while new ones come in.
`timescale 1ns / 1ps
`default_nettype none
module linear_contrast_stretch (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [lcs_pkg::S_TDATA_W-1:0] s_tdata,  // pixel_in
  input  wire logic [lcs_pkg::S_TUSER_W-1:0] s_tuser,  // operation, frame_start
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [lcs_pkg::M_TDATA_W-1:0]      m_tdata,  // pixel_out
  output logic [lcs_pkg::M_TUSER_W-1:0]      m_tuser   // flat_frame
);

  lcs_pkg::lcs_cmd_t cmd;
  lcs_pkg::lcs_status_t status;

  lcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_op     (s_tuser[lcs_pkg::USER_OP]),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid)
  );

  lcs_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
`default_nettype wire
